[hdl/bdq_pkg.sv]
// Shared types and constants for the bounded deque core.
// No dependencies; every other file refers to this package by scoped name.
package bdq_pkg;

   // fixed field widths of the request and response words
   localparam int MODE_W   = 3;
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH_LEFT  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_RIGHT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_LEFT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_RIGHT  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NONE       = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_DONE  = 4'b1000
   } bdq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic exec;      // apply the operation
      logic load_end;  // refill a cached end from the memory read
      logic load_out;  // load the response register
   } bdq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_fetch;  // a pop left entries behind: new end must be read
   } bdq_stat_type;

endpackage

[hdl/bdq_if.sv]
// Valid/ready channel interfaces for the request and response words.
// Depends on bdq_pkg for the field widths.
interface bdq_req_if;
   logic                             valid;
   logic                             ready;
   logic [bdq_pkg::MODE_W-1:0]       mode;
   logic [bdq_pkg::FIELD_W-1:0]      push_value;

   modport source (output valid, mode, push_value, input ready);
   modport sink   (input valid, mode, push_value, output ready);
endinterface

interface bdq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bdq_pkg::STATUS_W-1:0]     status;
   logic [bdq_pkg::FIELD_W-1:0]      popped_value;
   logic [bdq_pkg::COUNT_W-1:0]      count_after;
   logic                             is_empty;
   logic                             is_full;
   logic [bdq_pkg::FIELD_W-1:0]      left_value;
   logic [bdq_pkg::FIELD_W-1:0]      right_value;

   modport source (output valid, status, popped_value, count_after, is_empty, is_full,
                   left_value, right_value, input ready);
   modport sink   (input valid, status, popped_value, count_after, is_empty, is_full,
                   left_value, right_value, output ready);
endinterface

[hdl/bounded_deque_core.sv]
// Bounded double-ended queue of CAPACITY entries held in a ring memory.
// Each request word carries one operation (push left, push right, pop left,
// pop right, or none); each gives exactly one response word with status,
// popped value, count, empty/full flags and both end values. An item passes
// through the controller steps accept, execute and deliver; a pop that
// leaves entries behind adds a refill step before deliver, loading the cached end
// value from the registered read of the ring memory. The response word is
// loaded into the response register at the deliver step, which waits while
// the previous word still sits in the response register unaccepted.
// The response register frees the input side: a new request is taken while
// the previous response waits. Depends on bdq_pkg, bdq_if, bdq_ctrl and
// bdq_dpath.
module bounded_deque_core #(
   parameter int CAPACITY    = 16,  // entries, 1 to 31
   parameter int VALUE_WIDTH = 16   // stored bits per entry, 1 to 16
) (
   input  logic       clock,
   input  logic       reset,
   bdq_req_if.sink    req_if,
   bdq_rsp_if.source  rsp_if
);

   bdq_pkg::bdq_cmd_type  cmd;
   bdq_pkg::bdq_stat_type stat;

   // sequencer: accept, execute, optional end refill, deliver
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // storage, pointers and the response word
   bdq_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .mode         (req_if.mode),
      .push_value   (req_if.push_value),
      .status       (rsp_if.status),
      .popped_value (rsp_if.popped_value),
      .count_after  (rsp_if.count_after),
      .is_empty     (rsp_if.is_empty),
      .is_full      (rsp_if.is_full),
      .left_value   (rsp_if.left_value),
      .right_value  (rsp_if.right_value)
   );

endmodule

[hdl/bdq_ctrl.sv]
// Sequencing state machine of the bounded deque core.
// Depends on bdq_pkg; drives the datapath through bdq_cmd_type.
module bdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bdq_pkg::bdq_cmd_type  cmd,
   input  bdq_pkg::bdq_stat_type stat
);

   bdq_pkg::bdq_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         bdq_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = bdq_pkg::ST_EXEC;
            end
         end
         bdq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_fetch ? bdq_pkg::ST_FETCH : bdq_pkg::ST_DONE;
         end
         bdq_pkg::ST_FETCH: begin
            cmd.load_end = 1'b1;
            state_in     = bdq_pkg::ST_DONE;
         end
         bdq_pkg::ST_DONE: begin
            // wait only if the previous word is still held
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = bdq_pkg::ST_IDLE;
            end
         end
         default: state_in = bdq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == bdq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/bdq_dpath.sv]
// Datapath of the bounded deque core: ring memory, end pointers, count,
// cached end values and the response register. Depends on bdq_pkg.
module bdq_dpath #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bdq_pkg::bdq_cmd_type             cmd,
   output bdq_pkg::bdq_stat_type            stat,
   input  logic [bdq_pkg::MODE_W-1:0]       mode,
   input  logic [bdq_pkg::FIELD_W-1:0]      push_value,
   output logic [bdq_pkg::STATUS_W-1:0]     status,
   output logic [bdq_pkg::FIELD_W-1:0]      popped_value,
   output logic [bdq_pkg::COUNT_W-1:0]      count_after,
   output logic                             is_empty,
   output logic                             is_full,
   output logic [bdq_pkg::FIELD_W-1:0]      left_value,
   output logic [bdq_pkg::FIELD_W-1:0]      right_value
);

   localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [bdq_pkg::MODE_W-1:0] mode_ff;
   logic [VALUE_WIDTH-1:0]     value_ff;
   // invariant: right = left + count - 1 (mod CAPACITY)
   logic [PW-1:0]              left_ff, left_in;
   logic [PW-1:0]              right_ff, right_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [VALUE_WIDTH-1:0]     lv_ff, lv_in;
   logic [VALUE_WIDTH-1:0]     rv_ff, rv_in;
   logic [bdq_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [VALUE_WIDTH-1:0]     pop_ff, pop_in;
   logic                       fetch_left_ff, fetch_left_in;
   logic [VALUE_WIDTH-1:0]     rd_data_ff;

   logic [PW-1:0] left_inc, left_dec, right_inc, right_dec;
   logic [PW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic          is_push, is_pop, cnt_zero, cnt_full;

   logic [bdq_pkg::STATUS_W-1:0] out_status_ff;
   logic [bdq_pkg::FIELD_W-1:0]  out_pop_ff, out_lv_ff, out_rv_ff;
   logic [bdq_pkg::COUNT_W-1:0]  out_count_ff;
   logic                         out_empty_ff, out_full_ff;

   assign left_inc  = (left_ff  == LAST_SLOT) ? '0 : left_ff + PW'(1);
   assign left_dec  = (left_ff  == '0) ? LAST_SLOT : left_ff - PW'(1);
   assign right_inc = (right_ff == LAST_SLOT) ? '0 : right_ff + PW'(1);
   assign right_dec = (right_ff == '0) ? LAST_SLOT : right_ff - PW'(1);

   assign is_push  = (mode_ff == bdq_pkg::MODE_PUSH_LEFT) ||
                     (mode_ff == bdq_pkg::MODE_PUSH_RIGHT);
   assign is_pop   = (mode_ff == bdq_pkg::MODE_POP_LEFT) ||
                     (mode_ff == bdq_pkg::MODE_POP_RIGHT);
   assign cnt_zero = (count_ff == '0);
   assign cnt_full = (count_ff == FULL_COUNT);

   assign stat.need_fetch = is_pop && (count_ff > CW'(1));

   assign wr_addr = (mode_ff == bdq_pkg::MODE_PUSH_LEFT) ? left_dec : right_inc;
   assign rd_addr = (mode_ff == bdq_pkg::MODE_POP_LEFT)  ? left_inc : right_dec;
   assign wr_en   = cmd.exec && is_push && !cnt_full;

   always_comb begin
      left_in       = left_ff;
      right_in      = right_ff;
      count_in      = count_ff;
      lv_in         = lv_ff;
      rv_in         = rv_ff;
      st_in         = st_ff;
      pop_in        = pop_ff;
      fetch_left_in = fetch_left_ff;
      if (cmd.exec) begin
         st_in         = bdq_pkg::STATUS_OK;
         pop_in        = '0;
         fetch_left_in = (mode_ff == bdq_pkg::MODE_POP_LEFT);
         if (is_push) begin
            if (cnt_full) begin
               st_in = bdq_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               if (mode_ff == bdq_pkg::MODE_PUSH_LEFT) begin
                  left_in = left_dec;
                  lv_in   = value_ff;
                  if (cnt_zero) rv_in = value_ff;
               end else begin
                  right_in = right_inc;
                  rv_in    = value_ff;
                  if (cnt_zero) lv_in = value_ff;
               end
            end
         end else if (is_pop) begin
            if (cnt_zero) begin
               st_in = bdq_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               if (mode_ff == bdq_pkg::MODE_POP_LEFT) begin
                  pop_in  = lv_ff;
                  left_in = left_inc;
               end else begin
                  pop_in   = rv_ff;
                  right_in = right_dec;
               end
            end
         end
      end else if (cmd.load_end) begin
         if (fetch_left_ff) begin
            lv_in = rd_data_ff;
         end else begin
            rv_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= LAST_SLOT;
         count_ff <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode;
         value_ff <= VALUE_WIDTH'(push_value);
      end
      lv_ff         <= lv_in;
      rv_ff         <= rv_in;
      st_ff         <= st_in;
      pop_ff        <= pop_in;
      fetch_left_ff <= fetch_left_in;
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= st_ff;
         out_pop_ff    <= bdq_pkg::FIELD_W'(pop_ff);
         out_count_ff  <= bdq_pkg::COUNT_W'(count_ff);
         out_empty_ff  <= cnt_zero;
         out_full_ff   <= cnt_full;
         out_lv_ff     <= cnt_zero ? '0 : bdq_pkg::FIELD_W'(lv_ff);
         out_rv_ff     <= cnt_zero ? '0 : bdq_pkg::FIELD_W'(rv_ff);
      end
   end

   assign status       = out_status_ff;
   assign popped_value = out_pop_ff;
   assign count_after  = out_count_ff;
   assign is_empty     = out_empty_ff;
   assign is_full      = out_full_ff;
   assign left_value   = out_lv_ff;
   assign right_value  = out_rv_ff;

endmodule

[hdl/bdq_checker.sv]
// Port-level checks for bounded_deque_core, attached by bind.
// Depends on bdq_pkg for status codes and field widths.
module bdq_port_checker #(
   parameter int CAPACITY = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bdq_pkg::STATUS_W-1:0]  status,
   input logic [bdq_pkg::COUNT_W-1:0]   count_after,
   input logic                          is_empty,
   input logic                          is_full,
   input logic [bdq_pkg::FIELD_W-1:0]   popped_value,
   input logic [bdq_pkg::FIELD_W-1:0]   left_value,
   input logic [bdq_pkg::FIELD_W-1:0]   right_value
);

   localparam logic [bdq_pkg::COUNT_W-1:0] CAP_COUNT = bdq_pkg::COUNT_W'(CAPACITY);

   // held word: status, count and end values stay put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(count_after)
                                  && $stable(left_value) && $stable(right_value))
      else $error("response word changed while stalled");

   // empty word: flag, count and end values agree
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_empty |-> count_after == '0 && left_value == '0 && right_value == '0)
      else $error("empty flag disagrees with count or end values");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_full |-> count_after == CAP_COUNT && !is_empty)
      else $error("full flag disagrees with count");

   // a rejected word leaves the deque in the state that caused the rejection
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != bdq_pkg::STATUS_OK |->
         popped_value == '0 &&
         ((status == bdq_pkg::STATUS_FULL && is_full) ||
          (status == bdq_pkg::STATUS_EMPTY && is_empty)))
      else $error("rejected operation with inconsistent flags");

endmodule

bind bounded_deque_core bdq_port_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .status       (rsp_if.status),
   .count_after  (rsp_if.count_after),
   .is_empty     (rsp_if.is_empty),
   .is_full      (rsp_if.is_full),
   .popped_value (rsp_if.popped_value),
   .left_value   (rsp_if.left_value),
   .right_value  (rsp_if.right_value)
);
